// ----- hdl/pll_factor_calculator_macros.svh -----
// Assertion macros used by the PLL factor calculator top level.
`ifndef PLL_FACTOR_CALCULATOR_MACROS_SVH
`define PLL_FACTOR_CALCULATOR_MACROS_SVH

// Same-cycle implication, checked on every rising edge out of reset.
`define PFC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising edge out of reset.
`define PFC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/pfc_pkg.sv -----
// Types, constants and helper functions for the PLL factor calculator.
package pfc_pkg;

    // Frequency range after clamping (fits in 28 bits)
    localparam int FREQ_W = 28;
    localparam logic [31:0] FREQ_MAX = 32'd200000000;
    localparam logic [31:0] FREQ_MIN = 32'd250000;
    // At or below this the first post divider would exceed 128
    localparam logic [31:0] HIGH_DIV_EDGE = 32'd3125000;

    // Dividends of the post divider quotient
    localparam int REM_W = 29;
    localparam logic [REM_W-1:0] VCO_REF = 29'd400000000;
    localparam logic [REM_W-1:0] HIGH_DIV_REF = 29'd26666666;

    // Quotient is below 128 in both branches
    localparam int QUO_W = 7;
    localparam int REM_XW = REM_W + QUO_W - 1;

    localparam int PDIV_W = 8;
    localparam int ODIV_W = 4;
    localparam logic [ODIV_W-1:0] OUT_DIV_HIGH = 4'd15;
    localparam logic [ODIV_W-1:0] OUT_DIV_LOW = 4'd1;

    // VCO target stays below 2^30 (at most 600 MHz)
    localparam int TARGET_W = 30;

    // target * 8192 / 1e6 == target * 128 / 15625, split as
    // floor(target/15625)*128 + floor((target mod 15625)*128/15625)
    localparam int STEP_DIV = 15625;
    localparam int RECIP_W = 31;
    localparam int RECIP_SHIFT = 44;
    localparam logic [RECIP_W-1:0] RECIP = 31'd1125899907;  // ceil(2^44/15625)
    localparam int MPROD_W = TARGET_W + RECIP_W;
    localparam int QA_W = 16;
    localparam int RES_W = 14;
    localparam int LUT_W = 7;
    localparam int LUT_RECIP_W = 22;
    localparam int LUT_SHIFT = 28;
    localparam logic [LUT_RECIP_W-1:0] LUT_RECIP = 22'd2199024;  // ceil(2^35/15625)
    localparam int FRAC_W = 13;
    localparam int WHOLE_W = 10;

    // Divider entry
    typedef struct packed {
        logic [FREQ_W-1:0] freq;
        logic [REM_W-1:0]  rem;
        logic              high;
    } div_req_t;

    // Divider exit
    typedef struct packed {
        logic [FREQ_W-1:0] freq;
        logic [QUO_W-1:0]  quo;
        logic              high;
    } div_res_t;

    // Final settings
    typedef struct packed {
        logic [FRAC_W-1:0]  mult_fraction;
        logic [WHOLE_W-1:0] mult_integer;
        logic [ODIV_W-1:0]  output_divider;
        logic [PDIV_W-1:0]  post_divider;
    } pll_res_t;

    // floor(residue * 128 / 15625) by reciprocal multiply, exact for residue < 15625
    function automatic logic [LUT_W-1:0] frac_lut(input logic [RES_W-1:0] residue);
        logic [RES_W+LUT_RECIP_W-1:0] scaled;
        scaled = (RES_W+LUT_RECIP_W)'(residue) * (RES_W+LUT_RECIP_W)'(LUT_RECIP);
        return LUT_W'(scaled >> LUT_SHIFT);
    endfunction

endpackage

// ----- hdl/pfc_divider.sv -----
// Pipelined restoring divider: one post-divider quotient bit per stage.
module pfc_divider import pfc_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     in_valid,
    output logic     in_ready,
    input  div_req_t in_data,
    output logic     out_valid,
    input  logic     out_ready,
    output div_res_t out_data
);

    typedef struct packed {
        logic [FREQ_W-1:0] freq;
        logic [REM_W-1:0]  rem;
        logic [QUO_W-1:0]  quo;
        logic              high;
    } div_stage_t;

    div_stage_t stage_reg [QUO_W];
    logic       v_reg [QUO_W];
    logic       en [QUO_W+1];

    assign en[QUO_W] = out_ready;

    for (genvar i = 0; i < QUO_W; i++) begin : g_stage
        localparam int K = QUO_W - 1 - i;

        div_stage_t        src;
        logic              src_v;
        div_stage_t        stage_next;
        logic [REM_XW-1:0] shifted;
        logic [REM_XW-1:0] rem_ext;

        // Stage source: module input or the previous stage
        if (i == 0) begin : g_first
            assign src_v = in_valid;
            assign src = '{freq: in_data.freq, rem: in_data.rem, quo: '0,
                           high: in_data.high};
        end else begin : g_next
            assign src_v = v_reg[i-1];
            assign src = stage_reg[i-1];
        end

        // Trial subtract of freq << K
        always_comb begin
            shifted = REM_XW'(src.freq) << K;
            rem_ext = REM_XW'(src.rem);
            stage_next = src;
            if (rem_ext >= shifted) begin
                stage_next.rem = REM_W'(rem_ext - shifted);
                stage_next.quo = src.quo | (QUO_W'(1) << K);
            end
        end

        // Stage advances when empty or when the next one moves
        assign en[i] = !v_reg[i] || en[i+1];

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[i] <= 1'b0;
            end else if (en[i]) begin
                v_reg[i] <= src_v;
            end
        end

        always_ff @(posedge aclk) begin
            if (en[i] && src_v) begin
                stage_reg[i] <= stage_next;
            end
        end
    end

    assign in_ready = en[0];
    assign out_valid = v_reg[QUO_W-1];
    assign out_data = '{freq: stage_reg[QUO_W-1].freq, quo: stage_reg[QUO_W-1].quo,
                        high: stage_reg[QUO_W-1].high};

endmodule

// ----- hdl/pfc_scaler.sv -----
// VCO target product and its split into integer and 13-bit fraction.
module pfc_scaler import pfc_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     in_valid,
    output logic     in_ready,
    input  div_res_t in_data,
    output logic     out_valid,
    input  logic     out_ready,
    output pll_res_t out_data
);

    typedef struct packed {
        logic [TARGET_W-1:0] prod;
        logic [PDIV_W-1:0]   pdiv;
        logic                high;
    } sc_a_t;

    typedef struct packed {
        logic [TARGET_W-1:0] target;
        logic [PDIV_W-1:0]   pdiv;
        logic                high;
    } sc_b_t;

    typedef struct packed {
        logic [QA_W-1:0]     quo_step;
        logic [TARGET_W-1:0] target;
        logic [PDIV_W-1:0]   pdiv;
        logic                high;
    } sc_c_t;

    typedef struct packed {
        logic [QA_W-1:0]  quo_step;
        logic [RES_W-1:0] residue;
        logic [PDIV_W-1:0] pdiv;
        logic             high;
    } sc_d_t;

    sc_a_t a_reg, a_next;
    sc_b_t b_reg, b_next;
    sc_c_t c_reg, c_next;
    sc_d_t d_reg, d_next;
    logic  a_v_reg, b_v_reg, c_v_reg, d_v_reg;
    logic  a_en, b_en, c_en, d_en;

    logic [FREQ_W+PDIV_W-1:0]   fp_prod;
    logic [TARGET_W+ODIV_W-1:0] times15;
    logic [MPROD_W-1:0]         mprod;
    logic [TARGET_W-1:0]        back_step;

    // Stall chain: a stage moves when empty or when its successor moves
    assign d_en = !d_v_reg || out_ready;
    assign c_en = !c_v_reg || d_en;
    assign b_en = !b_v_reg || c_en;
    assign a_en = !a_v_reg || b_en;
    assign in_ready = a_en;

    // Stage A: post divider and f * pdiv
    always_comb begin
        a_next.pdiv = PDIV_W'(in_data.quo) + PDIV_W'(1);
        fp_prod = (FREQ_W+PDIV_W)'(in_data.freq) * (FREQ_W+PDIV_W)'(a_next.pdiv);
        a_next.prod = TARGET_W'(fp_prod);
        a_next.high = in_data.high;
    end

    // Stage B: in the high branch, apply output divider of 15 as (x << 4) - x
    always_comb begin
        times15 = ((TARGET_W+ODIV_W)'(a_reg.prod) << ODIV_W)
                - (TARGET_W+ODIV_W)'(a_reg.prod);
        b_next.target = a_reg.high ? TARGET_W'(times15) : a_reg.prod;
        b_next.pdiv = a_reg.pdiv;
        b_next.high = a_reg.high;
    end

    // Stage C: target / 15625 by reciprocal multiply
    always_comb begin
        mprod = MPROD_W'(b_reg.target) * MPROD_W'(RECIP);
        c_next.quo_step = QA_W'(mprod >> RECIP_SHIFT);
        c_next.target = b_reg.target;
        c_next.pdiv = b_reg.pdiv;
        c_next.high = b_reg.high;
    end

    // Stage D: target mod 15625
    always_comb begin
        back_step = TARGET_W'(c_reg.quo_step) * TARGET_W'(STEP_DIV);
        d_next.residue = RES_W'(c_reg.target - back_step);
        d_next.quo_step = c_reg.quo_step;
        d_next.pdiv = c_reg.pdiv;
        d_next.high = c_reg.high;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_v_reg <= 1'b0;
            b_v_reg <= 1'b0;
            c_v_reg <= 1'b0;
            d_v_reg <= 1'b0;
        end else begin
            if (a_en) a_v_reg <= in_valid;
            if (b_en) b_v_reg <= a_v_reg;
            if (c_en) c_v_reg <= b_v_reg;
            if (d_en) d_v_reg <= c_v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (a_en && in_valid) a_reg <= a_next;
        if (b_en && a_v_reg) b_reg <= b_next;
        if (c_en && b_v_reg) c_reg <= c_next;
        if (d_en && c_v_reg) d_reg <= d_next;
    end

    // Scaled value = quo_step * 128 + lut; integer is its top, fraction its low 13 bits
    assign out_valid = d_v_reg;
    assign out_data.post_divider = d_reg.pdiv;
    assign out_data.output_divider = d_reg.high ? OUT_DIV_HIGH : OUT_DIV_LOW;
    assign out_data.mult_integer = WHOLE_W'(d_reg.quo_step >> (FRAC_W - LUT_W));
    assign out_data.mult_fraction = {d_reg.quo_step[FRAC_W-LUT_W-1:0],
                                     frac_lut(d_reg.residue)};

endmodule

// ----- hdl/pll_factor_calculator.sv -----
// Top level of the PLL factor calculator: input stage, divider, scaler, output register.

// Turns a requested frequency in Hz into PLL post divider, output divider and a
// fractional VCO multiplier (integer part plus 13-bit fraction of 1 MHz). One
// transfer is taken per clock while the output is not held off; each result passes
// through the input register, the restoring divider, which resolves one of the seven
// post-divider quotient bits per stage, four scaling stages and the output register.
// A held-off output only stalls stages that already hold data, so bubbles are
// squeezed out.
`include "pll_factor_calculator_macros.svh"

module pll_factor_calculator import pfc_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] target_hz
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata    // [7:0] post_divider, [11:8] output_divider,
                                   // [21:12] mult_integer, [34:22] mult_fraction
);

    div_req_t in_req_reg, in_req_next;
    logic     in_v_reg;
    logic     in_en;

    logic     div_in_ready;
    logic     div_out_valid;
    div_res_t div_out;
    logic     sc_in_ready;
    logic     sc_out_valid;
    pll_res_t sc_out;

    pll_res_t m_data_reg;
    logic     m_valid_reg;
    logic     out_en;

    // Input stage: clamp and pick the branch from the raw value
    always_comb begin
        logic [31:0] clamped;
        clamped = s_tdata;
        if (s_tdata > FREQ_MAX) begin
            clamped = FREQ_MAX;
        end else if (s_tdata < FREQ_MIN) begin
            clamped = FREQ_MIN;
        end
        in_req_next.freq = FREQ_W'(clamped);
        in_req_next.high = (s_tdata <= HIGH_DIV_EDGE);
        in_req_next.rem = in_req_next.high ? HIGH_DIV_REF : VCO_REF;
    end

    assign in_en = !in_v_reg || div_in_ready;
    assign s_tready = in_en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_v_reg <= 1'b0;
        end else if (in_en) begin
            in_v_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_en && s_tvalid) begin
            in_req_reg <= in_req_next;
        end
    end

    pfc_divider u_divider (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (in_v_reg),
        .in_ready  (div_in_ready),
        .in_data   (in_req_reg),
        .out_valid (div_out_valid),
        .out_ready (sc_in_ready),
        .out_data  (div_out)
    );

    pfc_scaler u_scaler (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (div_out_valid),
        .in_ready  (sc_in_ready),
        .in_data   (div_out),
        .out_valid (sc_out_valid),
        .out_ready (out_en),
        .out_data  (sc_out)
    );

    // Output register
    assign out_en = !m_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_en) begin
            m_valid_reg <= sc_out_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_en && sc_out_valid) begin
            m_data_reg <= sc_out;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata = {5'b0, m_data_reg.mult_fraction, m_data_reg.mult_integer,
                      m_data_reg.output_divider, m_data_reg.post_divider};

    // Checks
    `PFC_ASSERT_NOW(a_ready_flow, m_tready, s_tready, "input stalled while output drains")
    `PFC_ASSERT_NOW(a_high_branch, m_valid_reg && m_data_reg.output_divider == OUT_DIV_HIGH, m_data_reg.post_divider >= PDIV_W'(1) && m_data_reg.post_divider <= PDIV_W'(107), "post divider out of range in divide-by-15 branch")
    `PFC_ASSERT_NOW(a_low_branch, m_valid_reg && m_data_reg.output_divider != OUT_DIV_HIGH, m_data_reg.output_divider == OUT_DIV_LOW && m_data_reg.post_divider >= PDIV_W'(2) && m_data_reg.post_divider <= PDIV_W'(128), "post divider out of range in direct branch")
    `PFC_ASSERT_NOW(a_mult_range, m_valid_reg, m_data_reg.mult_integer <= WHOLE_W'(600), "integer multiplier above VCO range")

endmodule
